/* rtl/core/whirl_pkg.sv */
// ----------------------------------------------------------------------------
// whirl_pkg
// Shared constants and byte functions for the Whirlpool compression engine.
// ----------------------------------------------------------------------------
`default_nettype none
package whirl_pkg;

  localparam int WordWidth   = 64;
  localparam int BlockWords  = 8;
  localparam int RoundCountDefault = 10;

  function automatic logic [3:0] box_e(input logic [3:0] x);
    logic [3:0] r;
    unique case (x)
      4'h0: r = 4'h1; 4'h1: r = 4'hB; 4'h2: r = 4'h9; 4'h3: r = 4'hC;
      4'h4: r = 4'hD; 4'h5: r = 4'h6; 4'h6: r = 4'hF; 4'h7: r = 4'h3;
      4'h8: r = 4'hE; 4'h9: r = 4'h8; 4'hA: r = 4'h7; 4'hB: r = 4'h4;
      4'hC: r = 4'hA; 4'hD: r = 4'h2; 4'hE: r = 4'h5; default: r = 4'h0;
    endcase
    return r;
  endfunction

  function automatic logic [3:0] box_ei(input logic [3:0] x);
    logic [3:0] r;
    unique case (x)
      4'h0: r = 4'hF; 4'h1: r = 4'h0; 4'h2: r = 4'hD; 4'h3: r = 4'h7;
      4'h4: r = 4'hB; 4'h5: r = 4'hE; 4'h6: r = 4'h5; 4'h7: r = 4'hA;
      4'h8: r = 4'h9; 4'h9: r = 4'h2; 4'hA: r = 4'hC; 4'hB: r = 4'h1;
      4'hC: r = 4'h3; 4'hD: r = 4'h4; 4'hE: r = 4'h8; default: r = 4'h6;
    endcase
    return r;
  endfunction

  function automatic logic [3:0] box_r(input logic [3:0] x);
    logic [3:0] r;
    unique case (x)
      4'h0: r = 4'h7; 4'h1: r = 4'hC; 4'h2: r = 4'hB; 4'h3: r = 4'hD;
      4'h4: r = 4'hE; 4'h5: r = 4'h4; 4'h6: r = 4'h9; 4'h7: r = 4'hF;
      4'h8: r = 4'h6; 4'h9: r = 4'h3; 4'hA: r = 4'h8; 4'hB: r = 4'hA;
      4'hC: r = 4'h2; 4'hD: r = 4'h5; 4'hE: r = 4'h1; default: r = 4'h0;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] sbox(input logic [7:0] x);
    logic [3:0] u, l, r;
    u = box_e(x[7:4]);
    l = box_ei(x[3:0]);
    r = box_r(u ^ l);
    return {box_e(u ^ r), box_ei(l ^ r)};
  endfunction

  // multiply by 2 in GF(2^8), polynomial 0x11D
  function automatic logic [7:0] xt(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1D : 8'h00);
  endfunction

endpackage
`default_nettype wire

/* rtl/core/whirl_round.sv */
// ----------------------------------------------------------------------------
// whirl_round
// One Whirlpool round: S-box, column shift, MDS mix, key add. Combinational.
// ----------------------------------------------------------------------------
`default_nettype none
module whirl_round
  import whirl_pkg::*;
(
  input  wire logic [511:0] state_in,  // word r in bits [511-64r -: 64]
  input  wire logic [511:0] key_in,
  output logic      [511:0] state_out
);

  logic [7:0] t  [8][8];
  logic [7:0] x2 [8][8];
  logic [7:0] x4 [8][8];
  logic [7:0] x8 [8][8];

  always_comb begin
    for (int r = 0; r < 8; r++) begin
      for (int c = 0; c < 8; c++) begin
        t[r][c]  = sbox(state_in[511 - 64 * ((r - c + 8) % 8) - 8 * c -: 8]);
        x2[r][c] = xt(t[r][c]);
        x4[r][c] = xt(x2[r][c]);
        x8[r][c] = xt(x4[r][c]);
      end
    end
    // row coefficients 1 1 4 1 8 5 2 9, circulant
    for (int r = 0; r < 8; r++) begin
      for (int c = 0; c < 8; c++) begin
        state_out[511 - 64 * r - 8 * c -: 8] =
            t[r][c]
          ^ t[r][(c + 7) % 8]
          ^ x4[r][(c + 6) % 8]
          ^ t[r][(c + 5) % 8]
          ^ x8[r][(c + 4) % 8]
          ^ x4[r][(c + 3) % 8] ^ t[r][(c + 3) % 8]
          ^ x2[r][(c + 2) % 8]
          ^ x8[r][(c + 1) % 8] ^ t[r][(c + 1) % 8]
          ^ key_in[511 - 64 * r - 8 * c -: 8];
      end
    end
  end

endmodule
`default_nettype wire

/* rtl/core/whirlpool_compression.sv */
// ----------------------------------------------------------------------------
// whirlpool_compression
// Whirlpool 512-bit compression engine with Miyaguchi-Preneel chaining.
// ----------------------------------------------------------------------------
// Rounds: a word that fills a block is followed by ROUND_COUNT rounds (one
//   shared round unit, used for key then state in each round).
// Input: words are taken one per cycle while s_tready is high (S_LOAD only).
// Digest: eight words follow a final block, one per cycle when taken.
// Reset: rst clears chaining value, word position and control; no sweep.
`default_nettype none
module whirlpool_compression
  import whirl_pkg::*;
#(
  parameter int ROUND_COUNT = RoundCountDefault
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [63:0] s_tdata,   // [63:0] message_word
  input  wire logic [1:0]  s_tuser,   // [0] first_block, [1] final_block
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [63:0]      m_tdata,   // [63:0] digest_word
  output logic             m_tlast    // last_word
);

  localparam int RndW = $clog2(ROUND_COUNT + 1);

  typedef enum logic [1:0] {S_LOAD, S_KEY, S_STATE, S_OUT} state_t;

  state_t          state;
  logic [511:0]    chain;     // chaining value
  logic [511:0]    buffer;    // message block, word 0 at top
  logic [511:0]    cstate;    // cipher state
  logic [511:0]    rkey;      // round key
  logic [2:0]      pos;       // next word position
  logic            is_final;
  logic [RndW-1:0] rnd;       // rounds done
  logic [2:0]      out_idx;

  logic [511:0] unit_in, unit_key, unit_out, rc;
  logic [7:0]   rc_base;

  // round constant: first row from S-box, remaining rows zero
  always_comb begin
    rc_base = 8'(8 * rnd);
    rc = '0;
    for (int i = 0; i < 8; i++) begin
      rc[511 - 8 * i -: 8] = sbox(rc_base + 8'(i));
    end
  end

  // shared round unit: key schedule in S_KEY, cipher round in S_STATE
  always_comb begin
    if (state == S_KEY) begin
      unit_in  = rkey;
      unit_key = rc;
    end else begin
      unit_in  = cstate;
      unit_key = rkey;
    end
  end

  whirl_round u_round (
    .state_in  (unit_in),
    .key_in    (unit_key),
    .state_out (unit_out)
  );

  logic [511:0] chain_eff, buffer_new;
  always_comb begin
    chain_eff  = (pos == 3'd0 && s_tuser[0]) ? '0 : chain;
    buffer_new = buffer;
    buffer_new[511 - 64 * pos -: 64] = s_tdata;
  end

  assign s_tready = (state == S_LOAD);
  assign m_tvalid = (state == S_OUT);
  assign m_tdata  = chain[511 - 64 * out_idx -: 64];
  assign m_tlast  = (out_idx == 3'd7);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_LOAD;
      chain    <= '0;
      pos      <= '0;
      rnd      <= '0;
      out_idx  <= '0;
      is_final <= 1'b0;
    end else begin
      unique case (state)
        S_LOAD: begin
          if (s_tvalid) begin
            chain  <= chain_eff;
            buffer <= buffer_new;
            pos    <= pos + 3'd1;
            if (pos == 3'd7) begin
              rkey     <= chain_eff;
              cstate   <= buffer_new ^ chain_eff;
              is_final <= s_tuser[1];
              rnd      <= '0;
              state    <= S_KEY;
            end
          end
        end
        S_KEY: begin
          rkey  <= unit_out;
          state <= S_STATE;
        end
        S_STATE: begin
          cstate <= unit_out;
          rnd    <= rnd + RndW'(1);
          if (rnd == RndW'(ROUND_COUNT - 1)) begin
            chain   <= chain ^ unit_out ^ buffer;
            out_idx <= '0;
            state   <= is_final ? S_OUT : S_LOAD;
          end else begin
            state <= S_KEY;
          end
        end
        S_OUT: begin
          if (m_tready) begin
            out_idx <= out_idx + 3'd1;
            if (out_idx == 3'd7) state <= S_LOAD;
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end

endmodule
`default_nettype wire
